// ===== hdl/sisa_pkg.sv =====
// ----------------------------------------------------------------------------
// sisa_pkg
// Shared types and constants of the sampled inverse suffix array lookup:
// field widths, table sizes, command and register codes, divider request and
// response.
// ----------------------------------------------------------------------------
package sisa_pkg;

   // field widths fixed by the interface
   localparam int DATA_W = 16;
   localparam int RATE_W = 7;
   localparam int SIZE_W = 17;
   localparam int CMD_W  = 2;

   // table depth (a power of two) and largest supported sampling rate
   localparam int MAX_POSITIONS = 65536;
   localparam int MAX_RATE      = 64;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD_SUFFIX = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_NEXT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 2'd2;

   // configuration register indexes
   localparam logic CSR_SAMPLING_RATE = 1'b0;
   localparam logic CSR_TEXT_SIZE     = 1'b1;

   // register reset values
   localparam logic [RATE_W-1:0] RATE_RESET = 7'd32;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 17'h10000;

   // divider start
   typedef struct packed {
      logic              go;
      logic [DATA_W-1:0] dividend;
      logic [RATE_W-1:0] divisor;
   } div_req_type;

   // divider result
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [RATE_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/sisa_div.sv =====
// ----------------------------------------------------------------------------
// sisa_div
// Restoring divider of a 16-bit value by the sampling rate, one quotient bit
// per cycle. The registered done strobe rises with the final quotient and remainder.
// ----------------------------------------------------------------------------
module sisa_div
   import sisa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] quot_ff, quot_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [RATE_W-1:0] divisor_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;

   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;
   logic              fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, quot_ff[DATA_W-1]};
      diff    = trial - {1'b0, divisor_ff};
      fits    = (trial >= {1'b0, divisor_ff});
      rem_in  = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quot_in = {quot_ff[DATA_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.go) begin
         quot_ff    <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (run_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== hdl/sampled_inverse_suffix_array.sv =====
// ----------------------------------------------------------------------------
// sampled_inverse_suffix_array
// Sample table and next-position table with a chained lookup for queries.
// ----------------------------------------------------------------------------
// A load-next request writes its entry directly and busy stays low. A load-suffix
// request keeps busy high through the bit-serial divider that splits the suffix
// value by the rate, then writes the sample if the remainder is zero. A query
// keeps busy high through the divider, one sample read, then (index mod rate)
// dependent next-table reads, one per cycle through the single read port,
// and its result strobes on rsp_valid in the first cycle with busy low. A query
// at or beyond text_size answers in the next cycle without going busy. The
// receiver cannot stall: each result shows for exactly one cycle. Both tables
// are MAX_POSITIONS deep (a power of two) and hold nothing until written.
// ----------------------------------------------------------------------------
module sampled_inverse_suffix_array
   import sisa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [DATA_W-1:0] req_index,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_position,
   output logic              rsp_out_of_range,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_POSITIONS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CHASE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [RATE_W-1:0] rate_ff;
   logic [SIZE_W-1:0] text_size_ff;
   logic              query_ff, query_in;
   logic [DATA_W-1:0] index_ff, index_in;
   logic [RATE_W-1:0] steps_ff, steps_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_position_ff, rsp_position_in;
   logic              rsp_oor_ff, rsp_oor_in;

   logic [RATE_W-1:0] rate_eff;
   logic              accept;
   logic              query_oor;
   logic [DATA_W-1:0] pos_cur;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [DATA_W-1:0] sample_mem [MAX_POSITIONS];
   logic [DATA_W-1:0] next_mem [MAX_POSITIONS];
   logic              sample_we;
   logic [ADDR_W-1:0] sample_addr;
   logic [DATA_W-1:0] sample_q;
   logic              next_we;
   logic [ADDR_W-1:0] next_waddr;
   logic [ADDR_W-1:0] next_raddr;
   logic [DATA_W-1:0] next_q;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         text_size_ff <= SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLING_RATE: rate_ff      <= csr_wdata[RATE_W-1:0];
            CSR_TEXT_SIZE:     text_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective rate: zero acts as one, clamp at the largest supported rate
   always_comb begin
      rate_eff = rate_ff;
      if (rate_ff == '0) begin
         rate_eff = RATE_W'(1);
      end else if (32'(rate_ff) > MAX_RATE) begin
         rate_eff = RATE_W'(MAX_RATE);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign query_oor = ({1'b0, req_index} >= text_size_ff);

   // current chain position: sample on the first step, next entry after that
   assign pos_cur     = (state_ff == ST_READ) ? sample_q : next_q;
   assign sample_addr = ADDR_W'(div_rsp.quotient);
   assign next_waddr  = ADDR_W'(req_index);
   assign next_raddr  = ADDR_W'(pos_cur);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      query_in         = query_ff;
      index_in         = index_ff;
      steps_in         = steps_ff;
      rsp_valid_in     = 1'b0;
      rsp_position_in  = pos_cur;
      rsp_oor_in       = 1'b0;
      sample_we        = 1'b0;
      next_we          = 1'b0;
      div_req.go       = 1'b0;
      div_req.dividend = (req_cmd == CMD_QUERY) ? req_index : req_value;
      div_req.divisor  = rate_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD_SUFFIX: begin
                     div_req.go = 1'b1;
                     query_in   = 1'b0;
                     index_in   = req_index;
                     state_in   = ST_DIV;
                  end
                  CMD_LOAD_NEXT: begin
                     next_we = 1'b1;
                  end
                  CMD_QUERY: begin
                     if (query_oor) begin
                        rsp_valid_in    = 1'b1;
                        rsp_position_in = '0;
                        rsp_oor_in      = 1'b1;
                     end else begin
                        div_req.go = 1'b1;
                        query_in   = 1'b1;
                        state_in   = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (query_ff) begin
                  // sample read issued this cycle at the quotient
                  steps_in = div_rsp.remainder;
                  state_in = ST_READ;
               end else begin
                  sample_we = (div_rsp.remainder == '0);
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_READ, ST_CHASE: begin
            if (steps_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               steps_in = steps_ff - 1'b1;
               state_in = ST_CHASE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      query_ff        <= query_in;
      index_ff        <= index_in;
      steps_ff        <= steps_in;
      rsp_position_ff <= rsp_position_in;
      rsp_oor_ff      <= rsp_oor_in;
   end

   // sample table; read every cycle, its data used only by queries; one request runs at a time
   always_ff @(posedge clock) begin
      if (sample_we) begin
         sample_mem[sample_addr] <= index_ff;
      end
      sample_q <= sample_mem[sample_addr];
   end

   // next-position table
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= req_value;
      end
      next_q <= next_mem[next_raddr];
   end

   sisa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // out-of-range query answers in the next cycle
   a_oor_answer: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_QUERY) && query_oor |=> rsp_valid && rsp_out_of_range)
      else $error("out-of-range query not answered");

   // divider finishes only while a request waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide phase");

   // load-next never makes the block busy
   a_next_idle: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_LOAD_NEXT) |=> !busy && !rsp_valid)
      else $error("load-next disturbed the sequencer");

   // a chained result ends the busy period
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> !busy && $past(busy))
      else $error("query result without completed chain");

endmodule
